FILE: hw/rtl/npm_pkg.sv
package npm_pkg;

    // field widths fixed by the stream format
    localparam int COEFF_W = 16;
    localparam int INDEX_W = 9;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 32;
    localparam int M_PAD_W = M_DATA_W - COEFF_W - INDEX_W;

    // tuser codes on the input side
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // cycles between the last multiply issue and the final result write
    localparam int DRAIN_CYCLES = 3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic load_we;
        logic res_rd;
        logic rd_last;
        logic rd_zero;
        logic mac_issue;
        logic mac_first;
        logic mac_last;
        logic mac_neg;
    } ctl_t;

    typedef struct packed {
        logic room;
    } sts_t;

endpackage

FILE: hw/rtl/npm_ram.sv
module npm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/npm_ctrl.sv
module npm_ctrl
    import npm_pkg::*;
#(
    parameter int COEFF_COUNT = 512,
    localparam int AW = $clog2(COEFF_COUNT)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tuser,
    output logic               s_tready,
    input  sts_t               sts,
    output ctl_t               ctl,
    output logic [AW-1:0]      load_addr,
    output logic [AW-1:0]      a_rd_addr,
    output logic [AW-1:0]      b_rd_addr,
    output logic [AW-1:0]      res_k,
    output logic [AW-1:0]      res_rd_addr,
    output logic [INDEX_W-1:0] rd_index
);

    localparam logic [AW-1:0] LAST_POS = AW'(COEFF_COUNT - 1);

    state_t        state_reg, state_next;
    logic [AW-1:0] load_pos_reg, load_pos_next;
    logic [AW-1:0] read_pos_reg, read_pos_next;
    logic [AW-1:0] i_reg, i_next;
    logic [AW-1:0] j_reg, j_next;
    logic [AW-1:0] k_reg, k_next;
    logic          neg_reg, neg_next;
    logic [1:0]    drain_reg, drain_next;
    logic          done_reg, done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            load_pos_reg <= '0;
            read_pos_reg <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            neg_reg      <= 1'b0;
            drain_reg    <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            load_pos_reg <= load_pos_next;
            read_pos_reg <= read_pos_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            neg_reg      <= neg_next;
            drain_reg    <= drain_next;
            done_reg     <= done_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        load_pos_next = load_pos_reg;
        read_pos_next = read_pos_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        neg_next      = neg_reg;
        drain_next    = drain_reg;
        done_next     = done_reg;
        ctl           = '0;
        s_tready      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = sts.room;
                if (s_tvalid && sts.room)
                begin
                    if (s_tuser == ACT_READ)
                    begin
                        ctl.res_rd  = 1'b1;
                        ctl.rd_last = (read_pos_reg == LAST_POS);
                        // no product formed yet: result reads as zero
                        ctl.rd_zero = !done_reg;
                        read_pos_next = (read_pos_reg == LAST_POS) ? '0 : read_pos_reg + AW'(1);
                    end
                    else
                    begin
                        ctl.load_we = 1'b1;
                        if (load_pos_reg == LAST_POS)
                        begin
                            load_pos_next = '0;
                            state_next    = ST_MAC;
                            i_next        = '0;
                            j_next        = '0;
                            k_next        = '0;
                            neg_next      = 1'b0;
                        end
                        else
                        begin
                            load_pos_next = load_pos_reg + AW'(1);
                        end
                    end
                end
            end

            ST_MAC:
            begin
                // output k collects a[i] * b[(k - i) mod n], negated once j wraps
                ctl.mac_issue = 1'b1;
                ctl.mac_first = (i_reg == '0);
                ctl.mac_last  = (i_reg == LAST_POS);
                ctl.mac_neg   = neg_reg;
                if (i_reg == LAST_POS)
                begin
                    i_next   = '0;
                    neg_next = 1'b0;
                    if (k_reg == LAST_POS)
                    begin
                        state_next = ST_DRAIN;
                        drain_next = '0;
                    end
                    else
                    begin
                        k_next = k_reg + AW'(1);
                        j_next = k_reg + AW'(1);
                    end
                end
                else
                begin
                    i_next = i_reg + AW'(1);
                    if (j_reg == '0)
                    begin
                        j_next   = LAST_POS;
                        neg_next = 1'b1;
                    end
                    else
                    begin
                        j_next = j_reg - AW'(1);
                    end
                end
            end

            ST_DRAIN:
            begin
                if (drain_reg == 2'(DRAIN_CYCLES - 1))
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    drain_next = drain_reg + 2'd1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign load_addr   = load_pos_reg;
    assign a_rd_addr   = i_reg;
    assign b_rd_addr   = j_reg;
    assign res_k       = k_reg;
    assign res_rd_addr = read_pos_reg;
    assign rd_index    = INDEX_W'(read_pos_reg);

endmodule

FILE: hw/rtl/npm_datapath.sv
module npm_datapath
    import npm_pkg::*;
#(
    parameter int COEFF_COUNT = 512,
    parameter int MODULUS_BITS = 16,
    localparam int AW = $clog2(COEFF_COUNT),
    localparam int MB = MODULUS_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ctl_t               ctl,
    input  logic [AW-1:0]      load_addr,
    input  logic [AW-1:0]      a_rd_addr,
    input  logic [AW-1:0]      b_rd_addr,
    input  logic [AW-1:0]      res_k,
    input  logic [AW-1:0]      res_rd_addr,
    input  logic [INDEX_W-1:0] rd_index,
    input  logic [MB-1:0]      a_wdata,
    input  logic [MB-1:0]      b_wdata,
    output sts_t               sts,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [MB-1:0]      out_coeff,
    output logic [INDEX_W-1:0] out_index,
    output logic               out_last
);

    logic [MB-1:0]   a_q, b_q, res_q;
    logic [2*MB-1:0] prod_full;
    logic [MB-1:0]   term;
    logic [MB-1:0]   acc_next;
    logic            res_we;

    // multiply pipeline control
    logic          s1_v_reg, s1_first_reg, s1_last_reg, s1_neg_reg;
    logic [AW-1:0] s1_k_reg;
    logic          s2_v_reg, s2_first_reg, s2_last_reg, s2_neg_reg;
    logic [AW-1:0] s2_k_reg;
    logic [MB-1:0] prod_reg;
    logic [MB-1:0] acc_reg;

    // result read in flight
    logic               rd_v_reg, rd_last_reg, rd_zero_reg;
    logic [INDEX_W-1:0] rd_idx_reg;

    // two-entry output queue
    logic [MB-1:0]      q_coeff_reg [2];
    logic [INDEX_W-1:0] q_idx_reg [2];
    logic               q_last_reg [2];
    logic               q_head_reg, q_head_next;
    logic [1:0]         q_count_reg, q_count_next;
    logic               q_tail;
    logic               pop;
    logic [2:0]         occ;

    npm_ram #(.WIDTH(MB), .DEPTH(COEFF_COUNT)) u_a_ram (
        .clk   (clk),
        .we    (ctl.load_we),
        .waddr (load_addr),
        .wdata (a_wdata),
        .raddr (a_rd_addr),
        .rdata (a_q)
    );

    npm_ram #(.WIDTH(MB), .DEPTH(COEFF_COUNT)) u_b_ram (
        .clk   (clk),
        .we    (ctl.load_we),
        .waddr (load_addr),
        .wdata (b_wdata),
        .raddr (b_rd_addr),
        .rdata (b_q)
    );

    npm_ram #(.WIDTH(MB), .DEPTH(COEFF_COUNT)) u_res_ram (
        .clk   (clk),
        .we    (res_we),
        .waddr (s2_k_reg),
        .wdata (acc_next),
        .raddr (res_rd_addr),
        .rdata (res_q)
    );

    // only the low bits survive modulo a power of two
    assign prod_full = a_q * b_q;
    assign term      = s2_neg_reg ? MB'(-prod_reg) : prod_reg;
    assign acc_next  = (s2_first_reg ? '0 : acc_reg) + term;
    assign res_we    = s2_v_reg && s2_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
            rd_v_reg    <= 1'b0;
            q_head_reg  <= 1'b0;
            q_count_reg <= '0;
        end
        else
        begin
            s1_v_reg    <= ctl.mac_issue;
            s2_v_reg    <= s1_v_reg;
            rd_v_reg    <= ctl.res_rd;
            q_head_reg  <= q_head_next;
            q_count_reg <= q_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg <= ctl.mac_first;
        s1_last_reg  <= ctl.mac_last;
        s1_neg_reg   <= ctl.mac_neg;
        s1_k_reg     <= res_k;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_neg_reg   <= s1_neg_reg;
        s2_k_reg     <= s1_k_reg;
        prod_reg     <= prod_full[MB-1:0];
        if (s2_v_reg)
        begin
            acc_reg <= acc_next;
        end
        rd_idx_reg  <= rd_index;
        rd_last_reg <= ctl.rd_last;
        rd_zero_reg <= ctl.rd_zero;
        if (rd_v_reg)
        begin
            q_coeff_reg[q_tail] <= rd_zero_reg ? '0 : res_q;
            q_idx_reg[q_tail]   <= rd_idx_reg;
            q_last_reg[q_tail]  <= rd_last_reg;
        end
    end

    assign out_valid = (q_count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign q_tail    = q_head_reg ^ q_count_reg[0];

    always_comb
    begin
        q_head_next  = q_head_reg ^ pop;
        q_count_next = q_count_reg + {1'b0, rd_v_reg} - {1'b0, pop};
    end

    // queued plus in flight, after this cycle's transfer, must leave a slot
    assign occ      = {1'b0, q_count_reg} + {2'b0, rd_v_reg} - {2'b0, pop};
    assign sts.room = (occ <= 3'd1);

    assign out_coeff = q_coeff_reg[q_head_reg];
    assign out_index = q_idx_reg[q_head_reg];
    assign out_last  = q_last_reg[q_head_reg];

endmodule

FILE: hw/rtl/negacyclic_poly_multiplier.sv
// Multiplies two polynomials of COEFF_COUNT coefficients modulo x^n + 1 and
// 2^MODULUS_BITS. A transfer with tuser 0 loads the next coefficient pair in
// index order; the load that fills the last index starts the product. A
// transfer with tuser 1 returns the next result coefficient (zero before the
// first product), wrapping after the last, which carries tlast. Up to two read
// results may wait at the output. The product is schoolbook with one
// multiply-accumulate per cycle, fed from the read ports of the two operand
// memories, and s_tready stays low from the last load until the product
// is written back. Operand bits above MODULUS_BITS do not change the result.
module negacyclic_poly_multiplier
    import npm_pkg::*;
#(
    parameter int COEFF_COUNT = 512,
    parameter int MODULUS_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // a_coeff[15:0], b_coeff[31:16]
    input  logic                s_tuser,   // action
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // coeff[15:0], index[24:16], zero[31:25]
    output logic                m_tlast
);

    localparam int AW = $clog2(COEFF_COUNT);

    ctl_t               ctl;
    sts_t               sts;
    logic [AW-1:0]      load_addr, a_rd_addr, b_rd_addr, res_k, res_rd_addr;
    logic [INDEX_W-1:0] rd_index;
    logic [MODULUS_BITS-1:0] out_coeff;
    logic [INDEX_W-1:0] out_index;

    npm_ctrl #(.COEFF_COUNT(COEFF_COUNT)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tuser     (s_tuser),
        .s_tready    (s_tready),
        .sts         (sts),
        .ctl         (ctl),
        .load_addr   (load_addr),
        .a_rd_addr   (a_rd_addr),
        .b_rd_addr   (b_rd_addr),
        .res_k       (res_k),
        .res_rd_addr (res_rd_addr),
        .rd_index    (rd_index)
    );

    npm_datapath #(.COEFF_COUNT(COEFF_COUNT), .MODULUS_BITS(MODULUS_BITS)) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .load_addr   (load_addr),
        .a_rd_addr   (a_rd_addr),
        .b_rd_addr   (b_rd_addr),
        .res_k       (res_k),
        .res_rd_addr (res_rd_addr),
        .rd_index    (rd_index),
        .a_wdata     (s_tdata[MODULUS_BITS-1:0]),
        .b_wdata     (s_tdata[COEFF_W +: MODULUS_BITS]),
        .sts         (sts),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_coeff   (out_coeff),
        .out_index   (out_index),
        .out_last    (m_tlast)
    );

    assign m_tdata = {M_PAD_W'(0), out_index, COEFF_W'(out_coeff)};

`ifndef SYNTH
    a_no_transfer_in_mac : assert property (@(posedge clk) disable iff (!rst_n)
        ctl.mac_issue |-> !s_tready)
        else $error("input transfer accepted during multiply");

    a_mac_after_load : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ctl.mac_issue) |-> $past(ctl.load_we))
        else $error("multiply started without a final load");

    a_last_index : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata[24:16] == INDEX_W'(COEFF_COUNT - 1)))
        else $error("tlast on a coefficient other than the last");
`endif

endmodule

FILE: bench/npm_coeff_checker.sv
module npm_coeff_checker
    import npm_pkg::*;
#(
    parameter int COEFF_COUNT = 512,
    parameter int MODULUS_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    input  logic                m_tlast,
    output int                  fail_count,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam bit [31:0] Q_MASK = (32'd1 << MODULUS_BITS) - 32'd1;

    typedef struct packed {
        logic [COEFF_W-1:0] coeff;
        logic [INDEX_W-1:0] idx;
        logic               last;
    } coeff_beat_t;

    bit [COEFF_W-1:0] op_a [COEFF_COUNT];
    bit [COEFF_W-1:0] op_b [COEFF_COUNT];
    bit [COEFF_W-1:0] product [COEFF_COUNT];
    bit [31:0]        fold_acc [COEFF_COUNT];
    int unsigned      load_pos;
    int unsigned      read_pos;
    coeff_beat_t      expected_coeffs [$];

    // schoolbook product, upper half folded back with a minus sign
    function void fold_product();
        bit [31:0] term;
        for (int k = 0; k < COEFF_COUNT; k++)
            fold_acc[k] = '0;
        for (int i = 0; i < COEFF_COUNT; i++)
        begin
            for (int j = 0; j < COEFF_COUNT; j++)
            begin
                term = 32'(op_a[i]) * 32'(op_b[j]);
                if (i + j < COEFF_COUNT)
                    fold_acc[i + j] += term;
                else
                    fold_acc[i + j - COEFF_COUNT] -= term;
            end
        end
        for (int k = 0; k < COEFF_COUNT; k++)
            product[k] = COEFF_W'(fold_acc[k] & Q_MASK);
    endfunction

    initial
    begin
        fail_count = 0;
        pending = 0;
        load_pos = 0;
        read_pos = 0;
        for (int k = 0; k < COEFF_COUNT; k++)
            product[k] = '0;
    end

    always @(posedge clk)
    begin
        coeff_beat_t got;
        coeff_beat_t want;
        if (rst_n)
        begin
            // output side first: a read accepted at this edge cannot answer yet
            if (m_tvalid && m_tready)
            begin
                got.coeff = m_tdata[COEFF_W-1:0];
                got.idx = m_tdata[COEFF_W +: INDEX_W];
                got.last = m_tlast;
                if (expected_coeffs.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got coeff %h index %0d last %b",
                             $time, got.coeff, got.idx, got.last);
                    fail_count++;
                end
                else
                begin
                    want = expected_coeffs.pop_front();
                    if (got != want)
                    begin
                        $display("%0t: result mismatch, expected coeff %h index %0d last %b, got coeff %h index %0d last %b",
                                 $time, want.coeff, want.idx, want.last,
                                 got.coeff, got.idx, got.last);
                        fail_count++;
                    end
                end
                if (m_tdata[M_DATA_W-1:COEFF_W+INDEX_W] != '0)
                begin
                    $display("%0t: pad bits mismatch, expected %h, got %h", $time,
                             {M_PAD_W{1'b0}}, m_tdata[M_DATA_W-1:COEFF_W+INDEX_W]);
                    fail_count++;
                end
            end

            if (s_tvalid && s_tready)
            begin
                if (s_tuser == ACT_LOAD)
                begin
                    op_a[load_pos] = s_tdata[COEFF_W-1:0];
                    op_b[load_pos] = s_tdata[COEFF_W +: COEFF_W];
                    load_pos++;
                    if (load_pos == COEFF_COUNT)
                    begin
                        fold_product();
                        load_pos = 0;
                    end
                end
                else
                begin
                    want.coeff = product[read_pos];
                    want.idx = INDEX_W'(read_pos);
                    want.last = (read_pos == COEFF_COUNT - 1);
                    expected_coeffs.push_back(want);
                    read_pos = (read_pos == COEFF_COUNT - 1) ? 0 : read_pos + 1;
                end
            end
            pending = expected_coeffs.size();
        end
    end

endmodule

FILE: bench/tb_negacyclic_poly_multiplier.sv
module tb_negacyclic_poly_multiplier;
    timeunit 1ns;
    timeprecision 1ps;

    import npm_pkg::*;

    localparam int N_COEFF = 512;
    localparam int Q_BITS = 16;
    localparam int READ_TARGET = 610;
    localparam int SECOND_LOADS = 48;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;    // a_coeff[15:0], b_coeff[31:16]
    logic                s_tuser;    // action
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;    // coeff[15:0], index[24:16], zero[31:25]
    logic                m_tlast;
    int                  fail_count;
    int                  pending;

    int                  burst_left;
    int                  reads_sent;

    negacyclic_poly_multiplier #(
        .COEFF_COUNT (N_COEFF),
        .MODULUS_BITS(Q_BITS)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    npm_coeff_checker #(
        .COEFF_COUNT (N_COEFF),
        .MODULUS_BITS(Q_BITS)
    ) i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .fail_count(fail_count),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #15ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [COEFF_W-1:0] pick_coeff();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return COEFF_W'(1) << $urandom_range(0, COEFF_W - 1);
            default: return COEFF_W'($urandom);
        endcase
    endfunction

    // bursts of back-to-back transfers, mostly separated by idle gaps
    task automatic pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic send_item(input logic act, input logic [COEFF_W-1:0] a,
                             input logic [COEFF_W-1:0] b);
        pace();
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {b, a};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_load(input logic [COEFF_W-1:0] a, input logic [COEFF_W-1:0] b);
        send_item(ACT_LOAD, a, b);
    endtask

    task automatic send_read();
        // data bits are don't-care on a read, so they carry noise
        send_item(ACT_READ, COEFF_W'($urandom), COEFF_W'($urandom));
        reads_sent++;
    endtask

    task automatic load_rest_of_set(input int first, input int stop, input int read_pct);
        for (int k = first; k < stop; k++)
        begin
            if ($urandom_range(0, 99) < read_pct)
                send_read();
            send_load(pick_coeff(), pick_coeff());
        end
    endtask

    initial
    begin : receiver
        int unsigned mode;
        int unsigned seg_len;
        int unsigned taken;
        int unsigned next_hold;
        m_tready = 1'b0;
        taken = 0;
        next_hold = 100;
        wait (rst_n === 1'b1);
        forever
        begin
            mode = $urandom_range(0, 3);
            seg_len = $urandom_range(4, 64);
            repeat (seg_len)
            begin
                @(posedge clk);
                if (m_tvalid && m_tready)
                    taken++;
                // long hold-off so the output fills and the input stalls
                if (taken >= next_hold)
                begin
                    next_hold += 250;
                    m_tready <= 1'b0;
                    repeat (120) @(posedge clk);
                end
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = ACT_LOAD;
        s_tdata = '0;
        burst_left = 0;
        reads_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reads before any product come back as zero
        repeat (4) send_read();

        // first operand set, extremes up front; the product lands mid-stream
        send_load(16'hFFFF, 16'hFFFF);
        send_load(16'h0000, 16'h0000);
        send_load(16'hFFFF, 16'h0001);
        send_load(16'h8000, 16'h8000);
        send_read();
        send_load(16'h0001, 16'hFFFF);
        send_load(16'hAAAA, 16'h5555);
        send_load(16'h5555, 16'hAAAA);
        send_load(16'h7FFF, 16'hFFFF);
        send_read();
        load_rest_of_set(8, N_COEFF, 20);

        repeat (30) send_read();

        // start of a second set with heavy interleaving, loads restart at index 0
        load_rest_of_set(0, SECOND_LOADS, 45);

        // keep reading past the index wrap
        while (reads_sent < READ_TARGET)
            send_read();
        s_tvalid <= 1'b0;

        // one more edge so the checker has seen the final transfer
        @(posedge clk);
        wait (pending == 0);
        repeat (16) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
